// ===== src/vwsp_pkg.sv =====
package vwsp_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAX_WORDS = 1024;
    localparam int DOMAIN_BITS = WORD_BITS + 1;
    localparam int IDX_BITS = $clog2(MAX_WORDS);
    localparam int OFF_BITS = $clog2(WORD_BITS + 1);

    typedef struct packed {
        logic [WORD_BITS-1:0]   value;
        logic [DOMAIN_BITS-1:0] domain_size;
        logic                   last_variable;
    } in_word_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] packed_word;
        logic [IDX_BITS-1:0]  word_index;
        logic                 last_word;
    } out_word_t;

    // ceil(log2(d)), zero for a domain of zero or one, capped at the word size
    function automatic logic [OFF_BITS-1:0] field_width(input logic [DOMAIN_BITS-1:0] d);
        logic [DOMAIN_BITS-1:0] x;
        logic [OFF_BITS:0]      w;
        x = d - DOMAIN_BITS'(1);
        w = '0;
        for (int i = 0; i < DOMAIN_BITS; i++) begin
            if (x[i]) begin
                w = (OFF_BITS + 1)'(i + 1);
            end
        end
        if (d <= DOMAIN_BITS'(1)) begin
            w = '0;
        end
        if (w > (OFF_BITS + 1)'(WORD_BITS)) begin
            w = (OFF_BITS + 1)'(WORD_BITS);
        end
        return w[OFF_BITS-1:0];
    endfunction

endpackage

// ===== src/variable_width_state_packer.sv =====
// a completed word goes into the registered result queue and is offered on m_ from there
// throughput: one variable per cycle; a variable may produce up to two words and the
// result queue drains one word per cycle when m_ready is high; s_ready drops above two
// reset (aresetn low, synchronous): empty accumulator, offset and word index zero,
// result queue emptied
module variable_width_state_packer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vwsp_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output vwsp_pkg::out_word_t m_data
);
    import vwsp_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR = $clog2(QDEPTH);
    localparam int QCNT = $clog2(QDEPTH + 1);

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [OFF_BITS-1:0]  off_reg, off_next;
    logic [IDX_BITS-1:0]  cnt_reg, cnt_next;

    out_word_t            q_reg [QDEPTH];
    logic [QPTR-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPTR-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QCNT-1:0]      fill_reg, fill_next;

    logic [OFF_BITS-1:0]  width;
    logic [OFF_BITS-1:0]  room;
    logic                 flush;
    logic [WORD_BITS-1:0] base_acc;
    logic [OFF_BITS-1:0]  base_off;
    logic [IDX_BITS-1:0]  cnt_inc;
    logic [IDX_BITS-1:0]  idx_cur;
    logic [WORD_BITS-1:0] field_mask;
    logic [OFF_BITS-1:0]  sh;
    logic [WORD_BITS-1:0] fill_acc;
    logic [OFF_BITS-1:0]  fill_off;
    out_word_t            res0, res1;
    logic [1:0]           n_push;
    logic                 accept;
    logic                 pop;

    assign accept = s_valid && s_ready;
    assign pop = m_valid && m_ready;
    assign s_ready = (fill_reg <= QCNT'(QDEPTH - 2));
    assign m_valid = (fill_reg != '0);
    assign m_data = q_reg[rd_ptr_reg];

    always_comb begin
        width = field_width(s_data.domain_size);
        room = OFF_BITS'(WORD_BITS) - off_reg;
        flush = (width > room);
        cnt_inc = (cnt_reg == IDX_BITS'(MAX_WORDS - 1)) ? '0 : cnt_reg + IDX_BITS'(1);
        base_acc = flush ? '0 : acc_reg;
        base_off = flush ? '0 : off_reg;
        idx_cur = flush ? cnt_inc : cnt_reg;
        // low bits mask for the field, empty for a zero-width field
        field_mask = (width == '0) ? '0
                   : ({WORD_BITS{1'b1}} >> (OFF_BITS'(WORD_BITS) - width));
        sh = OFF_BITS'(WORD_BITS) - base_off - width;
        fill_acc = base_acc | ((s_data.value & field_mask) << sh);
        fill_off = base_off + width;

        res1.packed_word = fill_acc;
        res1.word_index = idx_cur;
        res1.last_word = 1'b1;
        if (flush) begin
            res0.packed_word = acc_reg;
            res0.word_index = cnt_reg;
            res0.last_word = 1'b0;
        end else begin
            res0 = res1;
        end
        n_push = accept ? (2'(flush) + 2'(s_data.last_variable)) : 2'd0;
    end

    always_comb begin
        acc_next = acc_reg;
        off_next = off_reg;
        cnt_next = cnt_reg;
        if (accept) begin
            if (s_data.last_variable) begin
                acc_next = '0;
                off_next = '0;
                cnt_next = '0;
            end else begin
                acc_next = fill_acc;
                off_next = fill_off;
                cnt_next = idx_cur;
            end
        end
        wr_ptr_next = wr_ptr_reg + QPTR'(n_push);
        rd_ptr_next = rd_ptr_reg + QPTR'(pop);
        fill_next = fill_reg + QCNT'(n_push) - QCNT'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            off_reg <= '0;
            cnt_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            off_reg <= off_next;
            cnt_reg <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    // result queue: flushed word first, then the final word
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (n_push == 2'd2) begin
            q_reg[wr_ptr_reg + QPTR'(1)] <= res1;
        end
    end

endmodule
